// ===== hw/rtl/ncp_pkg.sv =====
// shared types, constants and the character code table for the nucleotide packer
package ncp_pkg;

  // code width selection held in the mode register
  typedef enum logic [1:0] {
    MODE_2BIT = 2'd0,
    MODE_3BIT = 2'd1,
    MODE_4BIT = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  // register index of the mode register on the configuration port
  localparam logic REG_CODE_MODE = 1'b0;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // code widths
  localparam logic [2:0] WIDTH_2 = 3'd2;
  localparam logic [2:0] WIDTH_3 = 3'd3;
  localparam logic [2:0] WIDTH_4 = 3'd4;

  // result queue depth and its pointer and count widths
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one result word
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_last;
    logic       status;
  } res_t;

  // outcome of the character lookup
  typedef struct packed {
    logic       valid;
    logic [2:0] width;
    logic [3:0] code;
  } map_t;

  // results produced for one character
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } pack_out_t;

  // fold to upper case and look the character up for the active mode
  function automatic map_t map_char(input logic [7:0] ch_in, input mode_e mode);
    logic [7:0] ch;
    map_t       m;
    ch = ch_in;
    if (ch >= "a" && ch <= "z") begin
      ch = ch - 8'd32;
    end
    m = '{valid: 1'b1, width: WIDTH_2, code: 4'd0};
    unique case (mode)
      MODE_2BIT: begin
        m.width = WIDTH_2;
        unique case (ch)
          "A": m.code = 4'd0;
          "C": m.code = 4'd1;
          "G": m.code = 4'd2;
          "T": m.code = 4'd3;
          default: m.valid = 1'b0;
        endcase
      end
      MODE_3BIT: begin
        m.width = WIDTH_3;
        unique case (ch)
          "A": m.code = 4'd0;
          "C": m.code = 4'd1;
          "N": m.code = 4'd2;
          "-": m.code = 4'd3;
          "G": m.code = 4'b0110;
          "T": m.code = 4'b0111;
          default: m.valid = 1'b0;
        endcase
      end
      MODE_4BIT: begin
        m.width = WIDTH_4;
        unique case (ch)
          "A": m.code = 4'd0;
          "C": m.code = 4'd1;
          "R": m.code = 4'd2;
          "K": m.code = 4'd3;
          "B": m.code = 4'd4;
          "D": m.code = 4'd5;
          "S": m.code = 4'd6;
          "N": m.code = 4'd7;
          "-": m.code = 4'd8;
          "W": m.code = 4'd9;
          "H": m.code = 4'd10;
          "V": m.code = 4'd11;
          "M": m.code = 4'd12;
          "Y": m.code = 4'd13;
          "G": m.code = 4'd14;
          "T": m.code = 4'd15;
          default: m.valid = 1'b0;
        endcase
      end
      default: m.valid = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/nucleotide_char_packer_top.sv =====
// top level of the nucleotide character packer: input stage, packer, result queue, mode register
// The block takes one ASCII character per word and packs its 2, 3 or 4 bit code
// (selected by code_mode at byte address 0) MSB first into bytes; a full byte
// leaves as a result word, and a character marked last flushes a zero-padded
// partial byte marked last. A character the mode does not accept gives one
// error word (byte 0, last 1, status 1) and drops pending bits. Each character
// is registered in the input stage, packed once the queue has room, and its zero
// to two result words go into a four-word queue; a new character is taken every
// cycle while the queue has room for two words, so the sustained rate is one
// character per cycle whenever no more than one byte leaves per character, and
// is set by the single-word output port otherwise. A character passes the input
// stage register and the result queue before its first result word leaves.
module nucleotide_char_packer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // character input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  // packed output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  packed_byte_o,
  output logic        byte_last_o,
  output logic        status_o
);
  import ncp_pkg::*;

  mode_e     mode_q, mode_d;
  logic      cfg_wr;
  logic      stg_valid_q, stg_valid_d;
  logic [7:0] stg_char_q;
  logic      stg_last_q;
  logic      adv;
  logic      room;
  logic      in_acc;
  pack_out_t pack;
  res_t      res;

  // mode register write and read back
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CODE_MODE);
  assign mode_d = cfg_wr ? mode_e'(pwdata[1:0]) : mode_q;
  assign prdata = (paddr[2] == REG_CODE_MODE) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_2BIT;
    end else begin
      mode_q <= mode_d;
    end
  end

  // input stage handshake
  assign adv         = stg_valid_q && room;
  assign in_ready_o  = !stg_valid_q || adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign stg_valid_d = in_acc || (stg_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_char_q <= char_code_i;
      stg_last_q <= last_char_i;
    end
  end

  // packing
  ncp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .char_code_i (stg_char_q),
    .last_char_i (stg_last_q),
    .mode_i      (mode_q),
    .pack_o      (pack)
  );

  // result queue
  ncp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv),
    .pack_i      (pack),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign packed_byte_o = res.packed_byte;
  assign byte_last_o   = res.byte_last;
  assign status_o      = res.status;

endmodule

// ===== hw/rtl/ncp_packer.sv =====
// bit accumulator: appends one code per character and forms up to two result words
module ncp_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  input  ncp_pkg::mode_e    mode_i,
  output ncp_pkg::pack_out_t pack_o
);
  import ncp_pkg::*;

  logic [7:0]  acc_q, acc_d;
  logic [2:0]  fill_q, fill_d;
  map_t        m;
  logic [10:0] comb;
  logic [3:0]  total;
  logic [2:0]  rem;
  logic        full;
  logic [7:0]  mask;
  logic [7:0]  residue;
  logic [7:0]  byte0;
  logic [7:0]  pad;
  logic        has_pad;
  res_t        full_res;
  res_t        pad_res;

  // lookup and bit merge
  always_comb begin
    m       = map_char(char_code_i, mode_i);
    comb    = ({3'b000, acc_q} << m.width) | {7'b0, m.code};
    total   = {1'b0, fill_q} + {1'b0, m.width};
    full    = total[3];
    rem     = total[2:0];
    byte0   = 8'(comb >> rem);
    mask    = 8'((9'd1 << rem) - 9'd1);
    residue = comb[7:0] & mask;
    pad     = 8'(residue << (4'd8 - {1'b0, rem}));
    has_pad = last_char_i && (rem != 3'd0);
  end

  // result words for this character
  always_comb begin
    full_res = '{packed_byte: byte0, byte_last: last_char_i && (rem == 3'd0),
                 status: STATUS_OK};
    pad_res  = '{packed_byte: pad, byte_last: 1'b1, status: STATUS_OK};
    if (!m.valid) begin
      pack_o.count = 2'd1;
      pack_o.res0  = '{packed_byte: 8'd0, byte_last: 1'b1, status: STATUS_BAD};
      pack_o.res1  = pad_res;
    end else begin
      pack_o.count = {1'b0, full} + {1'b0, has_pad};
      pack_o.res0  = full ? full_res : pad_res;
      pack_o.res1  = pad_res;
    end
  end

  // next accumulator contents
  always_comb begin
    acc_d  = acc_q;
    fill_d = fill_q;
    if (en_i) begin
      if (!m.valid || last_char_i) begin
        acc_d  = 8'd0;
        fill_d = 3'd0;
      end else begin
        acc_d  = residue;
        fill_d = rem;
      end
    end
  end

  // accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 8'd0;
      fill_q <= 3'd0;
    end else begin
      acc_q  <= acc_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hw/rtl/ncp_out_queue.sv =====
// result queue: takes up to two words per cycle, gives one word per cycle while the output is ready
module ncp_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ncp_pkg::pack_out_t pack_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ncp_pkg::res_t      res_o
);
  import ncp_pkg::*;

  res_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wr_next;
  logic [1:0]           n_push;
  logic                 pop;

  // pointer and count updates
  always_comb begin
    n_push  = push_i ? pack_i.count : 2'd0;
    pop     = out_valid_o && out_ready_i;
    wr_next = wr_q + QueuePtrW'(1);
    wr_d    = wr_q + QueuePtrW'(n_push);
    rd_d    = rd_q + QueuePtrW'(pop);
    cnt_d   = cnt_q + QueueCntW'(n_push) - QueueCntW'(pop);
  end

  // room for a full pair of words
  assign room_o      = cnt_q <= QueueCntW'(QueueDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign res_o       = entry_q[rd_q];

  // queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entry_q[wr_q] <= pack_i.res0;
    end
    if (n_push == 2'd2) begin
      entry_q[wr_next] <= pack_i.res1;
    end
  end

endmodule
